[sv/failed_login_lockout_table_defines.svh]
// Assertion macros for the failed-login lockout table
`ifndef FAILED_LOGIN_LOCKOUT_TABLE_DEFINES_SVH
`define FAILED_LOGIN_LOCKOUT_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
`define FLLT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fllt: same-cycle property violated");
`define FLLT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fllt: next-cycle property violated");
`else
`define FLLT_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define FLLT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[sv/fllt_pkg.sv]
// Types and constants shared by the lockout table modules
package fllt_pkg;

    localparam int unsigned ACT_W      = 2;
    localparam int unsigned HALF_W     = 64;
    localparam int unsigned TIME_W     = 48;
    localparam int unsigned FAIL_W     = 32;
    localparam int unsigned FREE_W     = 8;
    localparam int unsigned MS_W       = 32;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned DBL_W      = 6;

    localparam logic [DBL_W-1:0] DBL_MAX = 6'd33;

    localparam logic [FREE_W-1:0] FREE_FAILURES_RST   = 8'd5;
    localparam logic [MS_W-1:0]   LOCKOUT_BASE_RST    = 32'd30000;
    localparam logic [MS_W-1:0]   LOCKOUT_MAX_RST     = 32'd900000;

    localparam logic [CFG_IDX_W-1:0] CFG_FREE_FAILURES   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT_BASE_MS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT_MAX_MS  = 2'd2;

    typedef enum logic [ACT_W-1:0] {
        ACT_CHECK   = 2'd0,
        ACT_FAIL    = 2'd1,
        ACT_SUCCESS = 2'd2,
        ACT_CLEAR   = 2'd3
    } act_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EVAL,
        S_BACKOFF,
        S_COMMIT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic scan_run;
        logic eval;
        logic bo_step;
        logic commit;
        logic out_load;
    } ctl_t;

    typedef struct packed {
        act_t act;
        logic scan_done;
        logic bo_done;
        logic out_free;
    } sts_t;

endpackage

[sv/fllt_req_if.sv]
// Request channel: one action item per handshake
interface fllt_req_if;
    import fllt_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACT_W-1:0]    action;
    logic [HALF_W-1:0]   addr_high;
    logic [HALF_W-1:0]   addr_low;
    logic [TIME_W-1:0]   now_ms;

    modport source (output valid, output action, output addr_high, output addr_low,
                    output now_ms, input ready);
    modport sink   (input valid, input action, input addr_high, input addr_low,
                    input now_ms, output ready);
endinterface

[sv/fllt_rsp_if.sv]
// Response channel: one verdict item per request
interface fllt_rsp_if;
    import fllt_pkg::*;

    logic            valid;
    logic            ready;
    logic            allowed;
    logic [MS_W-1:0] wait_ms;

    modport source (output valid, output allowed, output wait_ms, input ready);
    modport sink   (input valid, input allowed, input wait_ms, output ready);
endinterface

[sv/fllt_cfg_if.sv]
// Configuration write channel
interface fllt_cfg_if;
    import fllt_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/fllt_ctrl.sv]
// Controller state machine sequencing scan, evaluation, back-off and commit
module fllt_ctrl
    import fllt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output ctl_t ctl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (sts.act == ACT_FAIL)
                begin
                    state_next = S_BACKOFF;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_BACKOFF:
            begin
                if (sts.bo_done)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl      = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                ctl.load = in_valid;
            end
            S_SCAN:
            begin
                ctl.scan_run = 1'b1;
            end
            S_EVAL:
            begin
                ctl.eval = 1'b1;
            end
            S_BACKOFF:
            begin
                ctl.bo_step = 1'b1;
            end
            S_COMMIT:
            begin
                ctl.commit = 1'b1;
            end
            S_DONE:
            begin
                ctl.out_load = sts.out_free;
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

endmodule

[sv/fllt_datapath.sv]
// Slot table, scan trackers, back-off unit, configuration and result registers
module fllt_datapath
    import fllt_pkg::*;
#(
    parameter int unsigned SLOTS      = 8,
    parameter int unsigned ADDR_BYTES = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ctl_t                  ctl,
    output sts_t                  sts,
    input  logic [ACT_W-1:0]      action,
    input  logic [HALF_W-1:0]     addr_high,
    input  logic [HALF_W-1:0]     addr_low,
    input  logic [TIME_W-1:0]     now_ms,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  out_allowed,
    output logic [MS_W-1:0]       out_retry
);

    localparam int unsigned ADDR_BITS = ADDR_BYTES * 8;
    localparam int unsigned IW        = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int unsigned CW        = $clog2(SLOTS + 1);
    localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

    // configuration
    logic [FREE_W-1:0] free_failures_reg;
    logic [MS_W-1:0]   lockout_base_reg;
    logic [MS_W-1:0]   lockout_max_reg;

    // captured item
    act_t                 act_reg;
    logic [ADDR_BITS-1:0] addr_reg;
    logic [TIME_W-1:0]    now_reg;

    // table
    logic [SLOTS-1:0]     used_reg;
    logic [ADDR_BITS-1:0] slot_addr_reg  [SLOTS];
    logic [FAIL_W-1:0]    slot_fail_reg  [SLOTS];
    logic [TIME_W-1:0]    slot_lock_reg  [SLOTS];
    logic [TIME_W-1:0]    slot_seen_reg  [SLOTS];

    // scan
    logic [CW-1:0]        issue_cnt_reg;
    logic                 rd_v_reg;
    logic [IW-1:0]        rd_idx_reg;
    logic [ADDR_BITS-1:0] rd_addr_reg;
    logic [FAIL_W-1:0]    rd_fail_reg;
    logic [TIME_W-1:0]    rd_lock_reg;
    logic [TIME_W-1:0]    rd_seen_reg;
    logic                 match_v_reg;
    logic [IW-1:0]        match_idx_reg;
    logic [FAIL_W-1:0]    match_fail_reg;
    logic [TIME_W-1:0]    match_lock_reg;
    logic                 free_v_reg;
    logic [IW-1:0]        free_idx_reg;
    logic                 lru_v_reg;
    logic [IW-1:0]        lru_idx_reg;
    logic [TIME_W-1:0]    lru_seen_reg;

    // evaluation and back-off
    logic [IW-1:0]        tgt_reg;
    logic [FAIL_W-1:0]    fail_new_reg;
    logic [TIME_W-1:0]    keep_lock_reg;
    logic                 over_reg;
    logic [FAIL_W-1:0]    extra_reg;
    logic [MS_W:0]        bo_lock_reg;
    logic [DBL_W-1:0]     bo_n_reg;

    // result
    logic                 res_allowed_reg;
    logic [MS_W-1:0]      res_retry_reg;
    logic                 out_valid_reg;
    logic                 out_allowed_reg;
    logic [MS_W-1:0]      out_retry_reg;

    logic [2*HALF_W-1:0]  addr_full;
    logic                 issue;
    logic                 rd_used;
    logic                 hit;
    logic [FAIL_W-1:0]    base_fail;
    logic [FAIL_W-1:0]    fail_inc;
    logic [FAIL_W-1:0]    free_ext;
    logic [TIME_W-1:0]    rem;
    logic                 bo_go;
    logic [MS_W-1:0]      lockout;
    logic [TIME_W:0]      until_sum;
    logic [TIME_W-1:0]    lock_wr;

    assign addr_full = {addr_high, addr_low};
    assign issue     = ctl.scan_run && (issue_cnt_reg != SLOTS_C);
    assign rd_used   = used_reg[rd_idx_reg];
    assign hit       = rd_used && (rd_addr_reg == addr_reg);
    assign base_fail = match_v_reg ? match_fail_reg : '0;
    assign fail_inc  = (base_fail == '1) ? base_fail : base_fail + FAIL_W'(1);
    assign free_ext  = {{(FAIL_W-FREE_W){1'b0}}, free_failures_reg};
    assign rem       = match_lock_reg - now_reg;
    assign bo_go     = over_reg && (bo_n_reg < DBL_MAX)
                       && ({{(FAIL_W-DBL_W){1'b0}}, bo_n_reg} < extra_reg)
                       && (bo_lock_reg < {1'b0, lockout_max_reg});
    assign lockout   = (bo_lock_reg > {1'b0, lockout_max_reg}) ? lockout_max_reg
                                                               : bo_lock_reg[MS_W-1:0];
    assign until_sum = {1'b0, now_reg} + {{(TIME_W+1-MS_W){1'b0}}, lockout};
    assign lock_wr   = !over_reg ? keep_lock_reg
                                 : (until_sum[TIME_W] ? '1 : until_sum[TIME_W-1:0]);

    assign sts.act       = act_reg;
    assign sts.scan_done = (issue_cnt_reg == SLOTS_C) && !rd_v_reg;
    assign sts.bo_done   = !bo_go;
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign out_allowed = out_allowed_reg;
    assign out_retry   = out_retry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_failures_reg <= FREE_FAILURES_RST;
            lockout_base_reg  <= LOCKOUT_BASE_RST;
            lockout_max_reg   <= LOCKOUT_MAX_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FREE_FAILURES:   free_failures_reg <= cfg_data[FREE_W-1:0];
                CFG_LOCKOUT_BASE_MS: lockout_base_reg  <= cfg_data[MS_W-1:0];
                CFG_LOCKOUT_MAX_MS:  lockout_max_reg   <= cfg_data[MS_W-1:0];
                default:             free_failures_reg <= free_failures_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else if (ctl.eval && (act_reg == ACT_CLEAR))
        begin
            used_reg <= '0;
        end
        else if (ctl.eval && (act_reg == ACT_SUCCESS) && match_v_reg)
        begin
            used_reg[match_idx_reg] <= 1'b0;
        end
        else if (ctl.commit)
        begin
            used_reg[tgt_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.commit)
        begin
            slot_addr_reg[tgt_reg] <= addr_reg;
            slot_fail_reg[tgt_reg] <= fail_new_reg;
            slot_lock_reg[tgt_reg] <= lock_wr;
            slot_seen_reg[tgt_reg] <= now_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_idx_reg  <= issue_cnt_reg[IW-1:0];
            rd_addr_reg <= slot_addr_reg[issue_cnt_reg[IW-1:0]];
            rd_fail_reg <= slot_fail_reg[issue_cnt_reg[IW-1:0]];
            rd_lock_reg <= slot_lock_reg[issue_cnt_reg[IW-1:0]];
            rd_seen_reg <= slot_seen_reg[issue_cnt_reg[IW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_cnt_reg <= '0;
            rd_v_reg      <= 1'b0;
            match_v_reg   <= 1'b0;
            free_v_reg    <= 1'b0;
            lru_v_reg     <= 1'b0;
        end
        else if (ctl.load)
        begin
            issue_cnt_reg <= '0;
            rd_v_reg      <= 1'b0;
            match_v_reg   <= 1'b0;
            free_v_reg    <= 1'b0;
            lru_v_reg     <= 1'b0;
        end
        else if (ctl.scan_run)
        begin
            rd_v_reg <= issue;
            if (issue)
            begin
                issue_cnt_reg <= issue_cnt_reg + CW'(1);
            end
            if (rd_v_reg && hit && !match_v_reg)
            begin
                match_v_reg <= 1'b1;
            end
            if (rd_v_reg && !rd_used && !free_v_reg)
            begin
                free_v_reg <= 1'b1;
            end
            if (rd_v_reg && rd_used)
            begin
                lru_v_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.scan_run && rd_v_reg)
        begin
            if (hit && !match_v_reg)
            begin
                match_idx_reg  <= rd_idx_reg;
                match_fail_reg <= rd_fail_reg;
                match_lock_reg <= rd_lock_reg;
            end
            if (!rd_used && !free_v_reg)
            begin
                free_idx_reg <= rd_idx_reg;
            end
            if (rd_used && (!lru_v_reg || (rd_seen_reg < lru_seen_reg)))
            begin
                lru_idx_reg  <= rd_idx_reg;
                lru_seen_reg <= rd_seen_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            act_reg  <= act_t'(action);
            addr_reg <= addr_full[ADDR_BITS-1:0];
            now_reg  <= now_ms;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.eval)
        begin
            tgt_reg       <= match_v_reg ? match_idx_reg
                                         : (free_v_reg ? free_idx_reg : lru_idx_reg);
            fail_new_reg  <= fail_inc;
            keep_lock_reg <= match_v_reg ? match_lock_reg : '0;
            over_reg      <= fail_inc > free_ext;
            extra_reg     <= fail_inc - free_ext - FAIL_W'(1);
            bo_lock_reg   <= {1'b0, lockout_base_reg};
            bo_n_reg      <= '0;
        end
        else if (ctl.bo_step && bo_go)
        begin
            bo_lock_reg <= {bo_lock_reg[MS_W-1:0], 1'b0};
            bo_n_reg    <= bo_n_reg + DBL_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            res_allowed_reg <= 1'b1;
            res_retry_reg   <= '0;
        end
        else if (ctl.eval && (act_reg == ACT_CHECK) && match_v_reg
                 && (now_reg < match_lock_reg))
        begin
            res_allowed_reg <= 1'b0;
            res_retry_reg   <= (|rem[TIME_W-1:MS_W]) ? '1 : rem[MS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            out_allowed_reg <= res_allowed_reg;
            out_retry_reg   <= res_retry_reg;
        end
    end

endmodule

[sv/failed_login_lockout_table.sv]
// Check, success and clear pass through the slot scan and evaluation to the result register.
// A failure adds back-off doublings of the lockout time and a commit to the slot table.
// One item at a time; the slot scan goes through the single read port of the slot table,
// one slot per cycle.
// Reset clears all slot-used bits and loads the default configuration at once;
// there is no clearing pass.
`include "failed_login_lockout_table_defines.svh"

module failed_login_lockout_table
    import fllt_pkg::*;
#(
    parameter int unsigned SLOTS      = 8,
    parameter int unsigned ADDR_BYTES = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    fllt_req_if.sink   req,
    fllt_rsp_if.source rsp,
    fllt_cfg_if.sink   cfg
);

    ctl_t ctl;
    sts_t sts;

    assign cfg.ready = 1'b1;

    fllt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .sts      (sts),
        .ctl      (ctl)
    );

    fllt_datapath #(
        .SLOTS      (SLOTS),
        .ADDR_BYTES (ADDR_BYTES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .sts         (sts),
        .action      (req.action),
        .addr_high   (req.addr_high),
        .addr_low    (req.addr_low),
        .now_ms      (req.now_ms),
        .cfg_we      (cfg.valid),
        .cfg_index   (cfg.index),
        .cfg_data    (cfg.data),
        .out_valid   (rsp.valid),
        .out_ready   (rsp.ready),
        .out_allowed (rsp.allowed),
        .out_retry   (rsp.wait_ms)
    );

    `FLLT_ASSERT_SAME(a_no_overwrite, clk, rst_n, ctl.out_load, sts.out_free)
    `FLLT_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, req.valid && req.ready, !req.ready)
    `FLLT_ASSERT_SAME(a_commit_on_fail, clk, rst_n, ctl.commit, sts.act == ACT_FAIL)

endmodule
